// ===== hdl/crs_pkg.sv =====
`timescale 1ns / 1ps
// crs_pkg: constants, status codes, datapath operations and the
// controller/datapath command and status structs of the record store.
// No dependencies.
package crs_pkg;

  localparam int MAX_LEN      = 32;
  localparam int HDR_BYTES    = 3;
  localparam int SECTOR_DEPTH = MAX_LEN + HDR_BYTES + 1;
  localparam int SEC_AW       = $clog2(SECTOR_DEPTH);
  localparam int STG_AW       = $clog2(MAX_LEN);
  localparam int LEN_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int ST_W         = 3;

  localparam logic [BYTE_W-1:0] MAGIC_A = 8'h5A;
  localparam logic [BYTE_W-1:0] MAGIC_B = 8'hA5;
  localparam logic [BYTE_W-1:0] ERASED  = 8'hFF;

  localparam logic [ST_W-1:0] ST_SAME    = 3'd0;
  localparam logic [ST_W-1:0] ST_WRITTEN = 3'd1;
  localparam logic [ST_W-1:0] ST_LOAD    = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD     = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_READ,
    OP_CMP,
    OP_VAL,
    OP_ERASE,
    OP_WRITE,
    OP_SEEK,
    OP_NEXT
  } op_t;

  typedef struct packed {
    logic             take;
    op_t              op;
    logic             emit;
    logic             emit_pay;
    logic             emit_last;
    logic [ST_W-1:0]  emit_st;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_load;
    logic commit;
    logic cmp_bad;
    logic val_bad;
    logic at_pay_end;
    logic at_ck;
    logic len_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/crs_ifs.sv =====
`timescale 1ns / 1ps
// crs_in_if / crs_out_if: valid/ready channels of the record store.
// Depends on crs_pkg.
interface crs_in_if;
  import crs_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [LEN_W-1:0]  record_len;
  logic [BYTE_W-1:0] data;
  modport source (output valid, cmd, record_len, data, input ready);
  modport sink   (input valid, cmd, record_len, data, output ready);
endinterface

interface crs_out_if;
  import crs_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_res;
  logic              last;
  logic [ST_W-1:0]   status;
  modport source (output valid, data_res, last, status, input ready);
  modport sink   (input valid, data_res, last, status, output ready);
endinterface

// ===== hdl/crs_ctrl.sv =====
`timescale 1ns / 1ps
// crs_ctrl: sequencer for save, compare/rewrite and load of the record.
// Depends on crs_pkg.
module crs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  crs_pkg::dp_stat_t  stat,
  output crs_pkg::ctl_cmd_t  cmd
);
  import crs_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_CMP_RD  = 12'b000000000010,
    S_CMP_CHK = 12'b000000000100,
    S_ERASE   = 12'b000000001000,
    S_WR_RD   = 12'b000000010000,
    S_WR_WR   = 12'b000000100000,
    S_VAL_RD  = 12'b000001000000,
    S_VAL_CHK = 12'b000010000000,
    S_SEEK    = 12'b000100000000,
    S_LD_RD   = 12'b001000000000,
    S_LD_EMIT = 12'b010000000000,
    S_RESULT  = 12'b100000000000
  } state_t;

  state_t          state, state_next;
  logic [ST_W-1:0] res_st, res_st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      res_st <= ST_SAME;
    end else begin
      state  <= state_next;
      res_st <= res_st_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    res_st_next   = res_st;
    cmd.take      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.emit      = 1'b0;
    cmd.emit_pay  = 1'b0;
    cmd.emit_last = 1'b1;
    cmd.emit_st   = res_st;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          if (stat.is_load) state_next = S_VAL_RD;
          else if (stat.commit) state_next = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        cmd.op     = OP_READ;
        state_next = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        cmd.op = OP_CMP;
        if (stat.cmp_bad) begin
          state_next = S_ERASE;
        end else if (stat.at_pay_end) begin
          res_st_next = ST_SAME;
          state_next  = S_RESULT;
        end else begin
          state_next = S_CMP_RD;
        end
      end
      S_ERASE: begin
        cmd.op     = OP_ERASE;
        state_next = S_WR_RD;
      end
      S_WR_RD: begin
        cmd.op     = OP_READ;
        state_next = S_WR_WR;
      end
      S_WR_WR: begin
        cmd.op = OP_WRITE;
        if (stat.at_ck) begin
          res_st_next = ST_WRITTEN;
          state_next  = S_RESULT;
        end else begin
          state_next = S_WR_RD;
        end
      end
      S_VAL_RD: begin
        cmd.op     = OP_READ;
        state_next = S_VAL_CHK;
      end
      S_VAL_CHK: begin
        cmd.op = OP_VAL;
        if (stat.val_bad) begin
          res_st_next = ST_BAD;
          state_next  = S_RESULT;
        end else if (stat.at_ck) begin
          if (stat.len_zero) begin
            res_st_next = ST_EMPTY;
            state_next  = S_RESULT;
          end else begin
            state_next = S_SEEK;
          end
        end else begin
          state_next = S_VAL_RD;
        end
      end
      S_SEEK: begin
        cmd.op     = OP_SEEK;
        state_next = S_LD_RD;
      end
      S_LD_RD: begin
        cmd.op     = OP_READ;
        state_next = S_LD_EMIT;
      end
      S_LD_EMIT: begin
        cmd.emit_pay  = 1'b1;
        cmd.emit_last = stat.at_pay_end;
        cmd.emit_st   = ST_LOAD;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.op     = OP_NEXT;
          state_next = stat.at_pay_end ? S_IDLE : S_LD_RD;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/crs_dpath.sv =====
`timescale 1ns / 1ps
// crs_dpath: staging buffer, sector store with erase flags, walk address,
// checksum accumulator and output register. Depends on crs_pkg.
module crs_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  crs_pkg::ctl_cmd_t           cmd,
  output crs_pkg::dp_stat_t           stat,
  input  logic                        in_cmd,
  input  logic [crs_pkg::LEN_W-1:0]   in_len,
  input  logic [crs_pkg::BYTE_W-1:0]  in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [crs_pkg::BYTE_W-1:0]  data_res,
  output logic                        last,
  output logic [crs_pkg::ST_W-1:0]    status
);
  import crs_pkg::*;

  logic [BYTE_W-1:0]       staging [MAX_LEN];
  logic [BYTE_W-1:0]       sec_mem [SECTOR_DEPTH];
  logic [SECTOR_DEPTH-1:0] sec_vld;

  logic [LEN_W-1:0]  lin, len, count, cnt_inc;
  logic              commit_now;
  logic [SEC_AW-1:0] addr, pay_end, ck_addr;
  logic [STG_AW-1:0] stg_idx;
  logic              in_hdr, in_pay, at_ck;
  logic [BYTE_W-1:0] hdr_byte, sec_q, stg_q, sec_byte, wbyte, sum;
  logic              sec_q_vld;

  assign lin        = (in_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_len;
  assign cnt_inc    = count + 1'b1;
  assign commit_now = !in_cmd && ((lin == '0) || (cnt_inc >= lin));

  assign pay_end  = SEC_AW'(len) + SEC_AW'(HDR_BYTES - 1);
  assign ck_addr  = SEC_AW'(len) + SEC_AW'(HDR_BYTES);
  assign in_hdr   = addr < SEC_AW'(HDR_BYTES);
  assign in_pay   = !in_hdr && (addr <= pay_end);
  assign at_ck    = (addr == ck_addr);
  assign stg_idx  = STG_AW'(addr - SEC_AW'(HDR_BYTES));
  assign sec_byte = sec_q_vld ? sec_q : ERASED;

  always_comb begin
    if (addr == '0) hdr_byte = MAGIC_A;
    else if (addr == SEC_AW'(1)) hdr_byte = MAGIC_B;
    else hdr_byte = BYTE_W'(len);
  end

  always_comb begin
    if (in_hdr) wbyte = hdr_byte;
    else if (in_pay) wbyte = stg_q;
    else wbyte = sum;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sec_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take && !in_cmd) count <= commit_now ? '0 : cnt_inc;
      if (cmd.op == OP_ERASE) sec_vld <= '0;
      else if (cmd.op == OP_WRITE) sec_vld[addr] <= 1'b1;
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.take && !in_cmd && (lin != '0) && (count < LEN_W'(MAX_LEN)))
      staging[count[STG_AW-1:0]] <= in_data;
    if (cmd.op == OP_WRITE) sec_mem[addr] <= wbyte;
    if (cmd.op == OP_READ) begin
      stg_q     <= staging[stg_idx];
      sec_q     <= sec_mem[addr];
      sec_q_vld <= sec_vld[addr];
    end
  end

  // walk address and checksum
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      len  <= lin;
      addr <= '0;
      sum  <= '0;
    end else begin
      case (cmd.op)
        OP_CMP, OP_NEXT: addr <= addr + 1'b1;
        OP_VAL: begin
          addr <= addr + 1'b1;
          if (in_pay) sum <= sum + sec_byte;
        end
        OP_WRITE: begin
          addr <= addr + 1'b1;
          if (in_pay) sum <= sum + stg_q;
        end
        OP_ERASE: begin
          addr <= '0;
          sum  <= '0;
        end
        OP_SEEK: addr <= SEC_AW'(HDR_BYTES);
        default: ;
      endcase
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      data_res <= cmd.emit_pay ? sec_byte : '0;
      last     <= cmd.emit_last;
      status   <= cmd.emit_st;
    end
  end

  assign stat.is_load    = in_cmd;
  assign stat.commit     = commit_now;
  assign stat.cmp_bad    = in_hdr ? (sec_byte != hdr_byte) : (sec_byte != stg_q);
  assign stat.val_bad    = in_hdr ? (sec_byte != hdr_byte) : (at_ck && (sec_byte != sum));
  assign stat.at_pay_end = (addr == pay_end);
  assign stat.at_ck      = at_ck;
  assign stat.len_zero   = (len == '0);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ===== hdl/checksummed_record_store.sv =====
`timescale 1ns / 1ps
// Record store top: a save byte is taken in idle, giving no beat until the record completes.
// Commit: compares up to len+3 bytes (read, check); on mismatch erases, rewrites len+4 bytes
// (read, write), then result beat. Load: validates up to len+4 bytes, seeks, reads and emits
// each payload beat; loop is the single sector memory read port. A finished result beat waits
// in the output register. Reset (rst, sync): sector reads erased via per-entry flags cleared at once; count cleared.
module checksummed_record_store (
  input logic      clk,
  input logic      rst,
  crs_in_if.sink   in_ch,
  crs_out_if.source out_ch
);
  import crs_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  crs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  crs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_cmd    (in_ch.cmd),
    .in_len    (in_ch.record_len),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .data_res  (out_ch.data_res),
    .last      (out_ch.last),
    .status    (out_ch.status)
  );

endmodule

// ===== hdl/crs_chk.sv =====
`timescale 1ns / 1ps
// crs_chk: port-level checks of the record store, bound to the top level.
// Depends on crs_pkg and checksummed_record_store.
module crs_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_cmd,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [crs_pkg::BYTE_W-1:0]  data_res,
  input logic                        last,
  input logic [crs_pkg::ST_W-1:0]    status
);
  import crs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_res) && $stable(status)
      && $stable(last))
    else $error("result beat changed while stalled");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd |=> !in_ready)
    else $error("input taken during load");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_EMPTY)
    else $error("status code out of range");

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_LOAD) |-> last && (data_res == '0))
    else $error("non-load result not a single zero beat");

endmodule

bind checksummed_record_store crs_chk u_crs_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .data_res  (out_ch.data_res),
  .last      (out_ch.last),
  .status    (out_ch.status)
);

// ===== dv/tb_checksummed_record_store.sv =====
`timescale 1ns / 1ps
// tb_checksummed_record_store: self-checking bench for the record store. A queue-fed
// driver, a checking monitor and an in-bench model of sector, staging buffer and count.
// Depends on crs_pkg, crs_ifs (crs_in_if, crs_out_if) and checksummed_record_store.
module tb_checksummed_record_store;
  import crs_pkg::*;

  localparam logic CMD_SAVE = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam int PH_FREE      = 0;
  localparam int PH_SRC_IDLE  = 1;
  localparam int PH_SNK_STALL = 2;
  localparam int PH_BOTH      = 3;
  localparam int PHASE_BEATS  = 55;

  localparam int ITEMS_TOTAL  = 205;
  localparam int PRESSURE_AT  = 35;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic              cmd;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [ST_W-1:0]   status;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crs_in_if  in_if();
  crs_out_if out_if();

  checksummed_record_store i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model of the store
  logic [BYTE_W-1:0] sector_img [SECTOR_DEPTH];
  logic [BYTE_W-1:0] staged [MAX_LEN];
  logic [LEN_W-1:0]  staged_cnt;

  req_t  pending[$];
  beat_t expected_beats[$];
  logic [BYTE_W-1:0] gen_payload [MAX_LEN];

  int n_in, n_beats, n_err, n_commits, n_loads;
  int idle_cycles, hold_left, drv_phase, rcv_phase;
  bit in_taken, hold_done;
  bit src_idle, snk_stall;
  req_t  nxt;
  beat_t mon_got, mon_want;

  function automatic int clamp_len(logic [LEN_W-1:0] l);
    return (l > MAX_LEN) ? MAX_LEN : int'(l);
  endfunction

  function automatic bit header_matches(int len);
    return sector_img[0] == MAGIC_A && sector_img[1] == MAGIC_B &&
           sector_img[2] == len[BYTE_W-1:0];
  endfunction

  task automatic push_beat(logic [BYTE_W-1:0] d, logic l, logic [ST_W-1:0] st);
    beat_t b;
    b.data   = d;
    b.last   = l;
    b.status = st;
    expected_beats.push_back(b);
  endtask

  task automatic predict_store(req_t r);
    int len;
    bit same;
    logic [BYTE_W-1:0] sum;
    len = clamp_len(r.len);
    sum = '0;
    if (r.cmd == CMD_SAVE) begin
      if (len != 0) begin
        if (staged_cnt < MAX_LEN) staged[staged_cnt[STG_AW-1:0]] = r.data;
        staged_cnt = staged_cnt + 1'b1;
        if (staged_cnt < len) return;
      end
      staged_cnt = '0;
      n_commits++;
      same = header_matches(len);
      for (int i = 0; i < len; i++) begin
        if (sector_img[HDR_BYTES+i] != staged[i]) same = 1'b0;
      end
      if (!same) begin
        foreach (sector_img[i]) sector_img[i] = ERASED;
        sector_img[0] = MAGIC_A;
        sector_img[1] = MAGIC_B;
        sector_img[2] = len[BYTE_W-1:0];
        for (int i = 0; i < len; i++) begin
          sector_img[HDR_BYTES+i] = staged[i];
          sum += staged[i];
        end
        sector_img[HDR_BYTES+len] = sum;
      end
      push_beat('0, 1'b1, same ? ST_SAME : ST_WRITTEN);
    end else begin
      n_loads++;
      for (int i = 0; i < len; i++) sum += sector_img[HDR_BYTES+i];
      if (!header_matches(len) || sector_img[HDR_BYTES+len] != sum) begin
        push_beat('0, 1'b1, ST_BAD);
      end else if (len == 0) begin
        push_beat('0, 1'b1, ST_EMPTY);
      end else begin
        for (int i = 0; i < len; i++) push_beat(sector_img[HDR_BYTES+i], i == len - 1, ST_LOAD);
      end
    end
  endtask

  task automatic report_mismatch(string what, beat_t got, beat_t want);
    n_err++;
    $display("%0t ns %s: got data %02h last %0d status %0d, want data %02h last %0d status %0d",
             $realtime, what, got.data, got.last, got.status, want.data, want.last, want.status);
  endtask

  task automatic push_req(logic cmd, logic [LEN_W-1:0] len, logic [BYTE_W-1:0] data);
    req_t r;
    r.cmd  = cmd;
    r.len  = len;
    r.data = data;
    pending.push_back(r);
  endtask

  task automatic queue_save(logic [LEN_W-1:0] len, bit reuse);
    int n;
    n = clamp_len(len);
    if (n == 0) push_req(CMD_SAVE, len, BYTE_W'($urandom_range(0, 255)));
    for (int i = 0; i < n; i++) begin
      if (!reuse) gen_payload[i] = BYTE_W'($urandom_range(0, 255));
      push_req(CMD_SAVE, len, gen_payload[i]);
    end
  endtask

  // driver: a valid beat is held until taken
  always @(negedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      in_taken = 1'b0;
      drv_phase = (n_in / PHASE_BEATS) % 4;
      src_idle = (drv_phase == PH_SRC_IDLE && $urandom_range(0, 99) < 85) ||
                 (drv_phase == PH_BOTH && $urandom_range(0, 99) < 6);
      if (pending.size() != 0 && !src_idle) begin
        nxt = pending.pop_front();
        in_if.valid      <= 1'b1;
        in_if.cmd        <= nxt.cmd;
        in_if.record_len <= nxt.len;
        in_if.data       <= nxt.data;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back up the input
  always @(negedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (!hold_done && n_in >= PRESSURE_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      rcv_phase = (n_in / PHASE_BEATS) % 4;
      snk_stall = (rcv_phase == PH_SNK_STALL && $urandom_range(0, 99) < 85) ||
                  (rcv_phase == PH_BOTH && $urandom_range(0, 99) < 6);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !snk_stall;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && in_if.valid && in_if.ready) begin
      in_taken = 1'b1;
      n_in++;
      predict_store({in_if.cmd, in_if.record_len, in_if.data});
    end
    if (!rst && out_if.valid && out_if.ready) begin
      n_beats++;
      mon_got.data   = out_if.data_res;
      mon_got.last   = out_if.last;
      mon_got.status = out_if.status;
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", mon_got, '0);
      end else begin
        mon_want = expected_beats.pop_front();
        if (mon_got.data !== mon_want.data || mon_got.last !== mon_want.last ||
            mon_got.status !== mon_want.status) begin
          report_mismatch("wrong beat", mon_got, mon_want);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int pick, sel, big_left, brk_len, brk_cnt;
    logic [LEN_W-1:0] gen_len;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_SAVE;
    in_if.record_len = '0;
    in_if.data       = '0;
    out_if.ready     = 1'b0;
    foreach (sector_img[i]) sector_img[i] = ERASED;
    foreach (staged[i]) staged[i] = '0;
    staged_cnt = '0;

    // directed: erased sector, empty record, saturated length, repeat save,
    // load in the middle of a save, length shrinking mid-stream
    push_req(CMD_LOAD, 6'd0, 8'h00);
    push_req(CMD_SAVE, 6'd0, 8'hFF);
    push_req(CMD_SAVE, 6'd0, 8'h00);
    push_req(CMD_LOAD, 6'd0, 8'hFF);
    push_req(CMD_LOAD, 6'd63, 8'h00);
    push_req(CMD_SAVE, 6'd3, 8'hFF);
    push_req(CMD_SAVE, 6'd3, 8'h00);
    push_req(CMD_SAVE, 6'd3, 8'h80);
    push_req(CMD_SAVE, 6'd3, 8'hFF);
    push_req(CMD_SAVE, 6'd3, 8'h00);
    push_req(CMD_SAVE, 6'd3, 8'h80);
    push_req(CMD_LOAD, 6'd3, 8'h00);
    push_req(CMD_LOAD, 6'd2, 8'h00);
    push_req(CMD_SAVE, 6'd5, 8'h11);
    push_req(CMD_SAVE, 6'd5, 8'h22);
    push_req(CMD_LOAD, 6'd3, 8'h00);
    push_req(CMD_SAVE, 6'd1, 8'h33);
    push_req(CMD_LOAD, 6'd1, 8'h00);
    push_req(CMD_SAVE, 6'd1, 8'h11);
    push_req(CMD_SAVE, 6'd1, 8'h5A);
    push_req(CMD_LOAD, 6'd1, 8'h00);

    big_left = 2;
    gen_len  = '0;
    while (pending.size() < ITEMS_TOTAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_save(gen_len, 1'b1);
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 70) begin
            gen_len = LEN_W'($urandom_range(0, 6));
          end else if (sel < 90) begin
            gen_len = LEN_W'($urandom_range(7, 20));
          end else if (big_left > 0) begin
            big_left--;
            gen_len = LEN_W'($urandom_range(32, 63));
          end else begin
            gen_len = LEN_W'($urandom_range(0, 3));
          end
          queue_save(gen_len, 1'b0);
        end
      end else if (pick < 85) begin
        if ($urandom_range(0, 4) == 0) begin
          push_req(CMD_LOAD, LEN_W'($urandom_range(0, 63)), BYTE_W'($urandom_range(0, 255)));
        end else begin
          push_req(CMD_LOAD, gen_len, BYTE_W'($urandom_range(0, 255)));
        end
      end else begin
        // broken stream: part of a record, then a shorter length or a load
        brk_len = $urandom_range(3, 8);
        brk_cnt = $urandom_range(1, brk_len - 1);
        for (int i = 0; i < brk_cnt; i++) begin
          push_req(CMD_SAVE, LEN_W'(brk_len), BYTE_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) == 0) begin
          push_req(CMD_SAVE, LEN_W'($urandom_range(1, brk_cnt)),
                   BYTE_W'($urandom_range(0, 255)));
        end else begin
          push_req(CMD_LOAD, LEN_W'($urandom_range(0, 63)), BYTE_W'($urandom_range(0, 255)));
        end
      end
    end
    push_req(CMD_LOAD, gen_len, 8'h00);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_if.valid || expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_beats.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()),
                      '0, expected_beats[0]);
    end
    $display("run covered %0d input beats: %0d commits, %0d loads, %0d result beats checked",
             n_in, n_commits, n_loads, n_beats);
    $display("idle phases free/sender/receiver/both, one %0d-cycle receiver hold-off; %0d errors",
             HOLD_CYCLES, n_err);
    if (n_err == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/crs_pkg.sv
hdl/crs_ifs.sv
hdl/crs_ctrl.sv
hdl/crs_dpath.sv
hdl/checksummed_record_store.sv
hdl/crs_chk.sv
dv/tb_checksummed_record_store.sv
